[rtl/core/mcpq_pkg.sv]
`default_nettype none

package mcpq_pkg;

    localparam int CLASS_W  = 5;
    localparam int IN_TAG_W = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;
    localparam int DATA_W   = 24;   // tdata width on both channels

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_DROPPED = 3'd1,
        ST_FULL    = 3'd2,
        ST_INVALID = 3'd3,
        ST_POPPED  = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic {
        ACT_ADD = 1'b0,
        ACT_POP = 1'b1
    } action_t;

    // command to one row of cells
    typedef enum logic [1:0] {
        ROP_IDLE,
        ROP_PUSH_FRONT,
        ROP_APPEND,
        ROP_POP
    } row_op_t;

    // what one cell loads this cycle
    typedef enum logic [1:0] {
        COP_HOLD,
        COP_TAG,
        COP_PREV,
        COP_NEXT
    } cell_op_t;

endpackage

`default_nettype wire

[rtl/core/mcpq_cell.sv]
`default_nettype none

module mcpq_cell #(
    parameter int TAG_BITS = 16
) (
    input  wire logic                    clk,
    input  wire mcpq_pkg::cell_op_t      op,
    input  wire logic [TAG_BITS-1:0]     tag,
    input  wire logic [TAG_BITS-1:0]     prev_data,
    input  wire logic [TAG_BITS-1:0]     next_data,
    output logic      [TAG_BITS-1:0]     data
);

    logic [TAG_BITS-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            mcpq_pkg::COP_TAG:  data_reg <= tag;
            mcpq_pkg::COP_PREV: data_reg <= prev_data;
            mcpq_pkg::COP_NEXT: data_reg <= next_data;
            default:            data_reg <= data_reg;
        endcase
    end

    assign data = data_reg;

endmodule

`default_nettype wire

[rtl/core/mcpq_row.sv]
`default_nettype none

module mcpq_row #(
    parameter int TAG_BITS    = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int CNT_W       = 4
) (
    input  wire logic                    clk,
    input  wire mcpq_pkg::row_op_t       op,
    input  wire logic [CNT_W-1:0]        pos,    // tail slot for an append
    input  wire logic [TAG_BITS-1:0]     tag,
    output logic      [TAG_BITS-1:0]     head
);

    logic [TAG_BITS-1:0] cell_data [QUEUE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic [TAG_BITS-1:0] prev_d;
            logic [TAG_BITS-1:0] next_d;
            mcpq_pkg::cell_op_t  cop;

            if (i == 0)
            begin : g_first
                assign prev_d = tag;
            end
            else
            begin : g_mid_prev
                assign prev_d = cell_data[i-1];
            end

            // last cell keeps its value on pop; the count hides it
            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign next_d = cell_data[i];
            end
            else
            begin : g_mid_next
                assign next_d = cell_data[i+1];
            end

            always_comb
            begin
                cop = mcpq_pkg::COP_HOLD;
                case (op)
                    mcpq_pkg::ROP_PUSH_FRONT:
                        cop = (i == 0) ? mcpq_pkg::COP_TAG : mcpq_pkg::COP_PREV;
                    mcpq_pkg::ROP_APPEND:
                        cop = (pos == CNT_W'(i)) ? mcpq_pkg::COP_TAG : mcpq_pkg::COP_HOLD;
                    mcpq_pkg::ROP_POP:
                        cop = mcpq_pkg::COP_NEXT;
                    default:
                        cop = mcpq_pkg::COP_HOLD;
                endcase
            end

            mcpq_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk       (clk),
                .op        (cop),
                .tag       (tag),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[i])
            );
        end
    endgenerate

    assign head = cell_data[0];

endmodule

`default_nettype wire

[rtl/core/multi_class_priority_queue_bank.sv]
// Bank of NUM_QUEUES bounded queues, each QUEUE_DEPTH tags deep.
// Input channel s_axis: one command item per handshake. s_axis_tuser is the
// action (add or pop); s_axis_tdata carries class index, urgent flag and tag.
// An urgent add pushes at the head (dropping the tail when full), a regular
// add appends at the tail or is rejected when full, a pop takes the head.
// Output channel m_axis: one result item per command, status on m_axis_tuser,
// popped tag and the queue's new count on m_axis_tdata.
// Latency: the result is valid in the cycle after the command is accepted.
// Throughput: one command per cycle while no result waits on a low m_axis_tready. Each queue is a
// row of shift cells that moves as a whole on the accepting clock edge, and the count file is
// updated on that same edge, so the next command sees the finished state.
// Stall: the result sits in an output register; s_axis_tready stays high
// while that register is empty or being drained this cycle, and drops while
// a result waits on a low m_axis_tready.
// Reset: all queue counts go to zero and the output register empties. The
// tag cells are not cleared; only slots below a queue's count are ever read.
`default_nettype none

module multi_class_priority_queue_bank #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int TAG_BITS    = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [4:0] class_index, [5] urgent, [21:6] entry_tag, [23:22] zero
    input  wire logic [mcpq_pkg::DATA_W-1:0]    s_axis_tdata,
    // [0] action
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [15:0] popped_tag, [19:16] queue_count, [23:20] zero
    output logic      [mcpq_pkg::DATA_W-1:0]    m_axis_tdata,
    // [2:0] status
    output logic      [mcpq_pkg::STATUS_W-1:0]  m_axis_tuser
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int KEEP_W = (TAG_BITS < mcpq_pkg::IN_TAG_W) ? TAG_BITS
                                                            : mcpq_pkg::IN_TAG_W;

    logic [mcpq_pkg::CLASS_W-1:0]  in_class;
    logic                          in_urgent;
    logic [mcpq_pkg::IN_TAG_W-1:0] in_tag;
    mcpq_pkg::action_t             in_action;
    logic                          fire;

    logic [mcpq_pkg::CLASS_W-1:0]  class_m1;
    logic [QIDX_W-1:0]             q_idx;
    logic                          class_ok;
    logic [TAG_BITS-1:0]           tag_store;

    logic [CNT_W-1:0]              cnt_reg [NUM_QUEUES];
    logic [TAG_BITS-1:0]           heads   [NUM_QUEUES];

    logic [CNT_W-1:0]              cnt_cur;
    logic [CNT_W-1:0]              cnt_next;
    logic [TAG_BITS-1:0]           head_cur;
    logic                          q_full;
    logic                          q_empty;
    mcpq_pkg::row_op_t             row_cmd;
    mcpq_pkg::status_t             status_next;
    logic [mcpq_pkg::IN_TAG_W-1:0] popped_next;
    logic [mcpq_pkg::COUNT_W-1:0]  count_out_next;

    logic                          out_valid_reg;
    mcpq_pkg::status_t             out_status_reg;
    logic [mcpq_pkg::IN_TAG_W-1:0] out_popped_reg;
    logic [mcpq_pkg::COUNT_W-1:0]  out_count_reg;

    assign in_class  = s_axis_tdata[4:0];
    assign in_urgent = s_axis_tdata[5];
    assign in_tag    = s_axis_tdata[21:6];
    assign in_action = mcpq_pkg::action_t'(s_axis_tuser);

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;

    assign class_m1  = in_class - 5'd1;
    assign q_idx     = class_m1[QIDX_W-1:0];
    assign class_ok  = (in_class != '0) &&
                       (in_class <= mcpq_pkg::CLASS_W'(NUM_QUEUES));
    assign tag_store = TAG_BITS'(in_tag[KEEP_W-1:0]);

    assign cnt_cur  = cnt_reg[q_idx];
    assign head_cur = heads[q_idx];
    assign q_full   = (cnt_cur == CNT_W'(QUEUE_DEPTH));
    assign q_empty  = (cnt_cur == '0);

    always_comb
    begin
        row_cmd     = mcpq_pkg::ROP_IDLE;
        status_next = mcpq_pkg::ST_INVALID;
        popped_next = '0;
        cnt_next    = cnt_cur;
        if (class_ok)
        begin
            case (in_action)
                mcpq_pkg::ACT_ADD:
                begin
                    if (in_urgent)
                    begin
                        row_cmd = mcpq_pkg::ROP_PUSH_FRONT;
                        if (q_full)
                        begin
                            status_next = mcpq_pkg::ST_DROPPED;
                        end
                        else
                        begin
                            status_next = mcpq_pkg::ST_ADDED;
                            cnt_next    = CNT_W'(cnt_cur + 1'b1);
                        end
                    end
                    else if (q_full)
                    begin
                        status_next = mcpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        row_cmd     = mcpq_pkg::ROP_APPEND;
                        status_next = mcpq_pkg::ST_ADDED;
                        cnt_next    = CNT_W'(cnt_cur + 1'b1);
                    end
                end
                mcpq_pkg::ACT_POP:
                begin
                    if (q_empty)
                    begin
                        status_next = mcpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        row_cmd     = mcpq_pkg::ROP_POP;
                        status_next = mcpq_pkg::ST_POPPED;
                        popped_next = mcpq_pkg::IN_TAG_W'(head_cur[KEEP_W-1:0]);
                        cnt_next    = CNT_W'(cnt_cur - 1'b1);
                    end
                end
                default:
                begin
                    row_cmd = mcpq_pkg::ROP_IDLE;
                end
            endcase
        end
    end

    assign count_out_next = class_ok ? mcpq_pkg::COUNT_W'(cnt_next) : '0;

    genvar r;
    generate
        for (r = 0; r < NUM_QUEUES; r++)
        begin : g_row
            mcpq_pkg::row_op_t rop;

            assign rop = (fire && class_ok && (q_idx == QIDX_W'(r))) ? row_cmd
                                                                   : mcpq_pkg::ROP_IDLE;

            mcpq_row #(
                .TAG_BITS    (TAG_BITS),
                .QUEUE_DEPTH (QUEUE_DEPTH),
                .CNT_W       (CNT_W)
            ) u_row (
                .clk  (clk),
                .op   (rop),
                .pos  (cnt_cur),
                .tag  (tag_store),
                .head (heads[r])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg[r] <= '0;
                end
                else if (fire && class_ok && (q_idx == QIDX_W'(r)))
                begin
                    cnt_reg[r] <= cnt_next;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= status_next;
            out_popped_reg <= popped_next;
            out_count_reg  <= count_out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'd0, out_count_reg, out_popped_reg};

endmodule

`default_nettype wire

[rtl/core/mcpq_checker.sv]
`default_nettype none

module mcpq_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [mcpq_pkg::DATA_W-1:0]    s_axis_tdata,
    input  wire logic                           s_axis_tuser,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [mcpq_pkg::DATA_W-1:0]    m_axis_tdata,
    input  wire logic [mcpq_pkg::STATUS_W-1:0]  m_axis_tuser
);

    // every accepted command yields a result in the next cycle
    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after accepted item");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != mcpq_pkg::ST_POPPED) |->
            (m_axis_tdata[15:0] == 16'd0))
        else $error("tag on non-pop result");

    a_invalid_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == mcpq_pkg::ST_INVALID) |->
            (m_axis_tdata[19:16] == 4'd0))
        else $error("count on invalid class");

    // every add result (added, dropped or full) reports a non-empty queue
    a_count_sense: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == mcpq_pkg::ST_ADDED) ||
                          (m_axis_tuser == mcpq_pkg::ST_DROPPED) ||
                          (m_axis_tuser == mcpq_pkg::ST_FULL)) |->
            (m_axis_tdata[19:16] != 4'd0))
        else $error("add result with empty queue");

endmodule

bind multi_class_priority_queue_bank mcpq_checker u_mcpq_checker (.*);

`default_nettype wire
